// ===== hw/rtl/sliding_window_median_filter_assert.svh =====
// Assertion macros shared by the median filter RTL.
`ifndef SLIDING_WINDOW_MEDIAN_FILTER_ASSERT_SVH
`define SLIDING_WINDOW_MEDIAN_FILTER_ASSERT_SVH

`ifndef ASSERT_OFF
`define SWMF_ASSERT_IMPLY(label, clock, reset_n, cond, prop, msg) \
    label: assert property (@(posedge clock) disable iff (!reset_n) (cond) |-> (prop)) \
        else $error(msg);
`define SWMF_ASSERT_NEXT(label, clock, reset_n, cond, prop, msg) \
    label: assert property (@(posedge clock) disable iff (!reset_n) (cond) |=> (prop)) \
        else $error(msg);
`else
`define SWMF_ASSERT_IMPLY(label, clock, reset_n, cond, prop, msg)
`define SWMF_ASSERT_NEXT(label, clock, reset_n, cond, prop, msg)
`endif

`endif

// ===== hw/rtl/swmf_pkg.sv =====
// Shared constants for the sliding window median filter.
package swmf_pkg;

    localparam int SAMPLE_W = 16;
    localparam int HALF_W = 3;
    localparam int MAX_HALF_DEFAULT = 7;
    localparam logic [HALF_W-1:0] HALF_RESET = 3'd1;

endpackage

// ===== hw/rtl/sliding_window_median_filter.sv =====
// Top level of the sliding window median filter.
// Results pass the a_* stage and output register; one sample is taken per cycle unless
// in_stall is high. A flagged last sample with a full window yields 1 + h results, one per
// cycle unless out_stall is high; the input stalls while the raw tail is read back from the
// sample shift register. Reset clears the control state and sets half_width to 1; the
// sample shift register holds no defined value until samples are written into it.
`include "sliding_window_median_filter_assert.svh"

module sliding_window_median_filter #(
    parameter int MAX_HALF = swmf_pkg::MAX_HALF_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [swmf_pkg::SAMPLE_W-1:0] sample,
    input  logic                                 last_sample,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [swmf_pkg::SAMPLE_W-1:0] filtered_value,
    output logic                                 last_output,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic        [swmf_pkg::HALF_W-1:0]   cfg_data
);

    localparam int DEPTH = 2 * MAX_HALF + 1;
    localparam int HW = $clog2(MAX_HALF + 1);
    localparam int CW = HW + 1;
    localparam int IW = $clog2(DEPTH);
    localparam int SW = swmf_pkg::SAMPLE_W;

    logic [swmf_pkg::HALF_W-1:0] half_width_reg;
    logic [HW-1:0]               scan_half_reg, scan_half_next;
    logic [CW-1:0]               seen_reg, seen_next;
    logic signed [SW-1:0]        recent_reg [DEPTH];

    logic          a_valid_reg, a_valid_next;
    logic          a_head_reg, a_head_next;
    logic          a_med_reg, a_med_next;
    logic          a_last_reg, a_last_next;
    logic [HW-1:0] a_tail_reg, a_tail_next;

    logic                 out_valid_reg, out_valid_next;
    logic signed [SW-1:0] out_value_reg, out_value_next;
    logic                 out_last_reg, out_last_next;

    logic          accept;
    logic          load_ok;
    logic          a_final;
    logic [HW-1:0] h_eff;
    logic [HW-1:0] h_cur;
    logic [CW-1:0] w_cur;
    logic [CW-1:0] c_cur;
    logic [HW-1:0] tail_m1;
    logic [CW-1:0] w_scan;

    logic [DEPTH-1:0]     win;
    logic [DEPTH-1:0]     lt_vec [DEPTH];
    logic [DEPTH-1:0]     sel;
    logic signed [SW-1:0] median;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_width_reg <= swmf_pkg::HALF_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            half_width_reg <= cfg_data;
        end
    end

    always_comb
    begin
        if (half_width_reg == '0)
        begin
            h_eff = HW'(1);
        end
        else if (int'(half_width_reg) > MAX_HALF)
        begin
            h_eff = HW'(MAX_HALF);
        end
        else
        begin
            h_eff = HW'(half_width_reg);
        end
    end

    // The half width is latched on the first sample of each scan.
    assign h_cur = (seen_reg == '0) ? h_eff : scan_half_reg;
    assign w_cur = {h_cur, 1'b1};
    assign c_cur = (seen_reg >= w_cur) ? w_cur : seen_reg + CW'(1);

    assign load_ok = !out_valid_reg || !out_stall;
    assign a_final = a_head_reg ? (a_tail_reg == '0) : (a_tail_reg == HW'(1));
    assign in_stall = a_valid_reg && !(load_ok && a_final);
    assign accept = in_valid && !in_stall;

    always_comb
    begin
        scan_half_next = scan_half_reg;
        seen_next = seen_reg;
        if (accept)
        begin
            scan_half_next = h_cur;
            seen_next = last_sample ? '0 : c_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_half_reg <= HW'(1);
            seen_reg <= '0;
        end
        else
        begin
            scan_half_reg <= scan_half_next;
            seen_reg <= seen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            recent_reg[0] <= sample;
            for (int i = 1; i < DEPTH; i++)
            begin
                recent_reg[i] <= recent_reg[i-1];
            end
        end
    end

    // Rank selection: each window entry counts the entries that sort ahead of it.
    assign w_scan = {scan_half_reg, 1'b1};

    always_comb
    begin
        median = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            win[i] = CW'(i) < w_scan;
        end
        for (int i = 0; i < DEPTH; i++)
        begin
            for (int j = 0; j < DEPTH; j++)
            begin
                lt_vec[i][j] = win[j] && (j != i) &&
                    ((recent_reg[j] < recent_reg[i]) ||
                     ((recent_reg[j] == recent_reg[i]) && (j < i)));
            end
            sel[i] = win[i] && (IW'($countones(lt_vec[i])) == IW'(scan_half_reg));
            median = median | ({SW{sel[i]}} & recent_reg[i]);
        end
    end

    assign tail_m1 = a_tail_reg - HW'(1);

    always_comb
    begin
        a_valid_next = a_valid_reg;
        a_head_next = a_head_reg;
        a_med_next = a_med_reg;
        a_last_next = a_last_reg;
        a_tail_next = a_tail_reg;
        if (accept)
        begin
            a_head_next = (c_cur <= {1'b0, h_cur}) || (c_cur == w_cur);
            a_med_next = (c_cur == w_cur);
            a_last_next = last_sample;
            a_valid_next = a_head_next || last_sample;
            if (last_sample && (c_cur > {1'b0, h_cur}))
            begin
                a_tail_next = (c_cur == w_cur) ? h_cur : HW'(c_cur - {1'b0, h_cur});
            end
            else
            begin
                a_tail_next = '0;
            end
        end
        else if (a_valid_reg && load_ok)
        begin
            if (a_final)
            begin
                a_valid_next = 1'b0;
            end
            else if (a_head_reg)
            begin
                a_head_next = 1'b0;
            end
            else
            begin
                a_tail_next = tail_m1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            a_head_reg <= 1'b0;
            a_med_reg <= 1'b0;
            a_last_reg <= 1'b0;
            a_tail_reg <= '0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            a_head_reg <= a_head_next;
            a_med_reg <= a_med_next;
            a_last_reg <= a_last_next;
            a_tail_reg <= a_tail_next;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_value_next = out_value_reg;
        out_last_next = out_last_reg;
        if (load_ok)
        begin
            out_valid_next = a_valid_reg;
            out_last_next = a_last_reg && a_final;
            if (a_head_reg)
            begin
                out_value_next = a_med_reg ? median : recent_reg[0];
            end
            else
            begin
                out_value_next = recent_reg[IW'(tail_m1)];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_value_reg <= out_value_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid = out_valid_reg;
    assign filtered_value = out_value_reg;
    assign last_output = out_last_reg;

    `SWMF_ASSERT_IMPLY(a_tail_bound, clk, rst_n, a_valid_reg, a_tail_reg <= scan_half_reg, "tail count exceeds half width")
    `SWMF_ASSERT_IMPLY(a_tail_needs_last, clk, rst_n, a_valid_reg && (a_tail_reg != '0), a_last_reg, "tail pending on an unflagged sample")
    `SWMF_ASSERT_IMPLY(seen_bound, clk, rst_n, seen_reg != '0, seen_reg <= {scan_half_reg, 1'b1}, "sample count exceeds window")
    `SWMF_ASSERT_IMPLY(tail_holds_input, clk, rst_n, a_valid_reg && !a_head_reg && (a_tail_reg > HW'(1)), in_stall, "input taken during tail")
    `SWMF_ASSERT_NEXT(last_clears_count, clk, rst_n, accept && last_sample, seen_reg == '0, "scan count not cleared after last sample")

endmodule
